@@ src/tlfq_pkg.sv @@
// Package: shared types and constants for the three-level feedback scheduler.
`default_nettype none
package tlfq_pkg;
  localparam int unsigned QuantumW = 4;
  localparam int unsigned BurstW   = 16;
  localparam int unsigned SlotOutW = 4;
  localparam int unsigned LevelW   = 2;
  localparam logic [QuantumW-1:0] QuantumReset = 4'd4;

  localparam logic [LevelW-1:0] LevelTop = 2'd0;
  localparam logic [LevelW-1:0] LevelMid = 2'd1;
  localparam logic [LevelW-1:0] LevelBot = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StArrive,
    StTop,
    StScan,
    StMidRun,
    StBot,
    StOut
  } state_e;

  typedef struct packed {
    logic arrive;
    logic top_run;
    logic scan_clr;
    logic scan_step;
    logic mid_run;
    logic bot_run;
    logic idle_res;
  } cmd_t;

  typedef struct packed {
    logic top_empty;
    logic bot_empty;
    logic scan_done;
    logic found;
  } sts_t;
endpackage
`default_nettype wire

@@ src/tlfq_ctrl.sv @@
// Controller: sequences arrivals, ticks and the middle-level scan.
`default_nettype none
module tlfq_ctrl
  import tlfq_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  input  wire         in_type_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  input  wire sts_t   sts_i,
  output cmd_t        cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (!in_type_i) state_d = StArrive;
          else if (!sts_i.top_empty) state_d = StTop;
          else state_d = StScan;
        end
      end
      StArrive, StTop, StMidRun, StBot: state_d = StOut;
      StScan: begin
        if (sts_i.scan_done) begin
          if (sts_i.found) state_d = StMidRun;
          else if (!sts_i.bot_empty) state_d = StBot;
          else state_d = StOut;
        end
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.scan_clr = 1'b1;
      end
      StArrive: cmd_o.arrive = 1'b1;
      StTop: cmd_o.top_run = 1'b1;
      StScan: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.idle_res = sts_i.scan_done && !sts_i.found && sts_i.bot_empty;
      end
      StMidRun: cmd_o.mid_run = 1'b1;
      StBot: cmd_o.bot_run = 1'b1;
      StOut: out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ src/tlfq_dp.sv @@
// Datapath: slot tables, level queues, scan unit and result register.
`default_nettype none
module tlfq_dp
  import tlfq_pkg::*;
#(
  parameter int unsigned MaxJobs = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_fire_i,
  input  wire [BurstW-1:0]     burst_i,
  input  wire                  cfg_fire_i,
  input  wire [QuantumW-1:0]   cfg_data_i,
  input  wire cmd_t            cmd_i,
  output sts_t                 sts_o,
  output logic [15:0]          res_o
);
  localparam int unsigned SW = (MaxJobs > 1) ? $clog2(MaxJobs) : 1;
  localparam int unsigned CW = $clog2(MaxJobs + 1);
  localparam logic [CW-1:0] Depth = CW'(MaxJobs);
  localparam logic [CW:0]   Wrap  = (CW+1)'(MaxJobs);

  logic [QuantumW-1:0] quantum_q;
  logic [BurstW-1:0]   rem_q [MaxJobs];
  logic [QuantumW-1:0] used_q [MaxJobs];
  logic [MaxJobs-1:0]  busy_q, started_q, mid_q;
  logic [SW-1:0]       topm_q [MaxJobs];
  logic [SW-1:0]       botm_q [MaxJobs];
  logic [SW-1:0]       th_q, bh_q;
  logic [CW-1:0]       tc_q, bc_q;
  logic [BurstW-1:0]   burst_q;
  logic [SW-1:0]       scan_q, best_q;
  logic                found_q, done_q;
  logic [15:0]         res_q;

  logic [SW-1:0] free_s;
  logic          free_ok;
  always_comb begin
    free_s = '0;
    free_ok = 1'b0;
    for (int i = MaxJobs - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_s = SW'(i);
        free_ok = 1'b1;
      end
    end
  end

  // tail = head + count, wrapped once
  logic [SW-1:0] th_n, tt, bh_n, bt;
  logic [CW:0]   tsum, bsum;
  always_comb begin
    th_n = (th_q == SW'(MaxJobs - 1)) ? '0 : th_q + 1'b1;
    bh_n = (bh_q == SW'(MaxJobs - 1)) ? '0 : bh_q + 1'b1;
    tsum = (CW+1)'(th_q) + (CW+1)'(tc_q);
    bsum = (CW+1)'(bh_q) + (CW+1)'(bc_q);
    tt = (tsum >= Wrap) ? SW'(tsum - Wrap) : SW'(tsum);
    bt = (bsum >= Wrap) ? SW'(bsum - Wrap) : SW'(bsum);
  end

  logic [SW-1:0] rs;
  always_comb begin
    unique case (1'b1)
      cmd_i.top_run: rs = topm_q[th_q];
      cmd_i.bot_run: rs = botm_q[bh_q];
      default:       rs = best_q;
    endcase
  end
  logic run;
  assign run = cmd_i.top_run | cmd_i.mid_run | cmd_i.bot_run;
  logic [BurstW-1:0]   rem_n;
  logic [QuantumW-1:0] used_n;
  logic                fin;
  assign rem_n  = rem_q[rs] - 1'b1;
  assign used_n = used_q[rs] + 1'b1;
  assign fin    = (rem_n == '0);

  logic [LevelW-1:0] lvl;
  assign lvl = cmd_i.top_run ? LevelTop : (cmd_i.mid_run ? LevelMid : LevelBot);

  always_ff @(posedge clk_i) begin
    if (in_fire_i) burst_q <= burst_i;
    if (cmd_i.arrive && burst_q != '0 && free_ok) begin
      rem_q[free_s] <= burst_q;
      used_q[free_s] <= '0;
    end
    if (run) rem_q[rs] <= rem_n;
    if (cmd_i.top_run) used_q[rs] <= (used_n == quantum_q) ? '0 : used_n;
    if (cmd_i.arrive && burst_q != '0 && free_ok) topm_q[tt] <= free_s;
    if (cmd_i.top_run && !fin && used_n != quantum_q) topm_q[tt] <= rs;
    if ((cmd_i.mid_run || cmd_i.bot_run) && !fin) botm_q[bt] <= rs;
  end

  logic push_t, push_b;
  always_comb begin
    push_t = (cmd_i.arrive && burst_q != '0 && free_ok) ||
             (cmd_i.top_run && !fin && used_n != quantum_q);
    push_b = (cmd_i.mid_run || cmd_i.bot_run) && !fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumReset;
      busy_q <= '0; started_q <= '0; mid_q <= '0;
      th_q <= '0; bh_q <= '0; tc_q <= '0; bc_q <= '0;
      scan_q <= '0; found_q <= 1'b0; done_q <= 1'b0; best_q <= '0;
    end else begin
      if (cfg_fire_i) quantum_q <= cfg_data_i;
      if (cmd_i.arrive && burst_q != '0 && free_ok) begin
        busy_q[free_s] <= 1'b1;
        started_q[free_s] <= 1'b0;
        mid_q[free_s] <= 1'b0;
      end
      if (run) begin
        started_q[rs] <= 1'b1;
        if (fin) busy_q[rs] <= 1'b0;
      end
      if (cmd_i.top_run && !fin && used_n == quantum_q) mid_q[rs] <= 1'b1;
      if (cmd_i.mid_run) mid_q[rs] <= 1'b0;
      if (cmd_i.top_run) th_q <= th_n;
      if (cmd_i.bot_run) bh_q <= bh_n;
      tc_q <= tc_q - CW'(cmd_i.top_run) +
              CW'(push_t && (tc_q != Depth || cmd_i.top_run));
      bc_q <= bc_q - CW'(cmd_i.bot_run) +
              CW'(push_b && (bc_q != Depth || cmd_i.bot_run));
      if (cmd_i.scan_clr) begin
        scan_q <= '0; found_q <= 1'b0; done_q <= 1'b0; best_q <= '0;
      end else if (cmd_i.scan_step && !done_q) begin
        if (mid_q[scan_q] && (!found_q || rem_q[scan_q] < rem_q[best_q])) begin
          best_q <= scan_q;
          found_q <= 1'b1;
        end
        if (scan_q == SW'(MaxJobs - 1)) done_q <= 1'b1;
        else scan_q <= scan_q + 1'b1;
      end
    end
  end

  logic [SlotOutW-1:0] so_a, so_r;
  assign so_a = SlotOutW'(free_s);
  assign so_r = SlotOutW'(rs);

  always_ff @(posedge clk_i) begin
    if (cmd_i.arrive) begin
      res_q <= (burst_q != '0 && free_ok) ? {11'd0, so_a, 1'b1} : '0;
    end else if (run) begin
      res_q <= {6'd0, fin, !started_q[rs], lvl, 1'b1, so_r, 1'b0};
    end else if (cmd_i.idle_res) begin
      res_q <= '0;
    end
  end

  assign res_o = res_q;
  assign sts_o = '{top_empty: (tc_q == '0), bot_empty: (bc_q == '0),
                   scan_done: done_q, found: found_q};
endmodule
`default_nettype wire

@@ src/three_level_feedback_queue_scheduler_core.sv @@
// Top level: three-level feedback queue scheduler core.
//  channel   dir  beat
//  s_axis    in   tdata[15:0] burst, tuser[0] req_type
//  m_axis    out  tdata[9:0] accepted, job_slot[4:1], ran, level[7:6], first_run, finished
//  cfg       in   cfg_data_i[3:0] quantum
// Arrival or tick served by the top level: StArrive or StTop, then StOut. Any other
// tick scans the middle level one slot per cycle, then runs a middle or bottom job in
// StMidRun or StBot, or goes to StOut when nothing runs. One item at a time; the result
// is held until taken. Reset clears control state; slot tables are written on arrival.
`default_nettype none
module three_level_feedback_queue_scheduler_core
  import tlfq_pkg::*;
#(
  parameter int unsigned MaxJobs = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [15:0]  s_axis_tdata,   // burst
  input  wire         s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // accepted, job_slot, ran, level, first_run, finished
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [3:0]   cfg_data_i      // quantum
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  tlfq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_type_i(s_axis_tuser), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  tlfq_dp #(.MaxJobs(MaxJobs)) u_dp (
    .clk_i, .rst_ni,
    .in_fire_i(s_axis_tvalid & s_axis_tready), .burst_i(s_axis_tdata),
    .cfg_fire_i(cfg_valid_i), .cfg_data_i(cfg_data_i),
    .cmd_i(cmd), .sts_o(sts), .res_o(m_axis_tdata)
  );
endmodule
`default_nettype wire

@@ sim/tb_three_level_feedback_queue_scheduler_core.sv @@
// Testbench for the three-level feedback queue scheduler core: predictor, driver, monitor.
`default_nettype none
module tb_three_level_feedback_queue_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tlfq_pkg::*;

  localparam int unsigned Slots = 16;
  localparam logic ReqArrive = 1'b0;
  localparam logic ReqTick   = 1'b1;

  typedef struct packed {
    logic             req;
    logic [BurstW-1:0] burst;
  } job_req_t;

  // lowest bit last
  typedef struct packed {
    logic                finished;
    logic                first_run;
    logic [LevelW-1:0]   level;
    logic                ran;
    logic [SlotOutW-1:0] job_slot;
    logic                accepted;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_data_i = '0;

  three_level_feedback_queue_scheduler_core dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // scheduler state mirror
  logic [QuantumW-1:0] sch_quantum;
  logic [BurstW-1:0]   rem_t [Slots];
  logic [3:0]          used_q [Slots];
  logic                busy [Slots];
  logic                started [Slots];
  logic                in_mid [Slots];
  int unsigned         top_q [$];
  int unsigned         bot_q [$];

  job_req_t   pending_jobs [$];
  sched_res_t expected_res [$];
  int errors = 0;
  bit hold_off = 0;
  bit feeding = 0;
  bit taken = 0;

  function automatic void sched_reset();
    sch_quantum = QuantumReset;
    for (int i = 0; i < Slots; i++) begin
      rem_t[i] = '0; used_q[i] = '0; busy[i] = 0; started[i] = 0; in_mid[i] = 0;
    end
    top_q.delete();
    bot_q.delete();
  endfunction

  function automatic bit run_unit(int unsigned s, output logic first);
    first = !started[s];
    started[s] = 1;
    rem_t[s] = rem_t[s] - 1'b1;
    if (rem_t[s] == 0) begin
      busy[s] = 0;
      return 1;
    end
    return 0;
  endfunction

  function automatic sched_res_t schedule(job_req_t it);
    sched_res_t r;
    int unsigned s;
    bit found;
    r = '0;
    if (it.req == ReqArrive) begin
      if (it.burst != 0) begin
        for (s = 0; s < Slots; s++) if (!busy[s]) break;
        if (s < Slots) begin
          busy[s] = 1; started[s] = 0; in_mid[s] = 0;
          rem_t[s] = it.burst; used_q[s] = '0;
          top_q.insert(top_q.size(), s);
          r.accepted = 1; r.job_slot = s[3:0];
        end
      end
    end else if (top_q.size() != 0) begin
      s = top_q.pop_front();
      r.ran = 1; r.level = LevelTop; r.job_slot = s[3:0];
      used_q[s] = used_q[s] + 1'b1;
      r.finished = run_unit(s, r.first_run);
      if (!r.finished) begin
        if (used_q[s] == sch_quantum) begin
          used_q[s] = '0; in_mid[s] = 1;
        end else top_q.insert(top_q.size(), s);
      end
    end else begin
      found = 0; s = 0;
      for (int i = 0; i < Slots; i++)
        if (in_mid[i] && (!found || rem_t[i] < rem_t[s])) begin
          s = i; found = 1;
        end
      if (found) begin
        in_mid[s] = 0;
        r.ran = 1; r.level = LevelMid; r.job_slot = s[3:0];
        r.finished = run_unit(s, r.first_run);
        if (!r.finished) bot_q.insert(bot_q.size(), s);
      end else if (bot_q.size() != 0) begin
        s = bot_q.pop_front();
        r.ran = 1; r.level = LevelBot; r.job_slot = s[3:0];
        r.finished = run_unit(s, r.first_run);
        if (!r.finished) bot_q.insert(bot_q.size(), s);
      end
    end
    return r;
  endfunction

  // driver: bursts and gaps; a beat on offer is held until taken
  int burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !taken)) begin
      taken = 0;
      if (pending_jobs.size() == 0 || !feeding) begin
        s_axis_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_jobs[0].req;
        s_axis_tdata <= pending_jobs[0].burst;
        if (burst_left > 0) burst_left = burst_left - 1;
        else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      taken = 1;
      expected_res.insert(expected_res.size(), schedule(pending_jobs.pop_front()));
    end
  end

  // receiver stall pattern
  int rx_phase = 0;
  always @(negedge clk_i) begin
    rx_phase = rx_phase + 1;
    if (hold_off) m_axis_tready <= 1'b0;
    else if ((rx_phase / 200) % 3 == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk_i) begin
    sched_res_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[9:0];
      if (expected_res.size() == 0) begin
        $error("unexpected result beat %h", got);
        errors++;
      end else begin
        exp_r = expected_res.pop_front();
        if (got.accepted !== exp_r.accepted) begin
          $error("accepted exp %0d got %0d", exp_r.accepted, got.accepted); errors++;
        end
        if (got.job_slot !== exp_r.job_slot) begin
          $error("job_slot exp %0d got %0d", exp_r.job_slot, got.job_slot); errors++;
        end
        if (got.ran !== exp_r.ran) begin
          $error("ran exp %0d got %0d", exp_r.ran, got.ran); errors++;
        end
        if (got.level !== exp_r.level) begin
          $error("level exp %0d got %0d", exp_r.level, got.level); errors++;
        end
        if (got.first_run !== exp_r.first_run) begin
          $error("first_run exp %0d got %0d", exp_r.first_run, got.first_run); errors++;
        end
        if (got.finished !== exp_r.finished) begin
          $error("finished exp %0d got %0d", exp_r.finished, got.finished); errors++;
        end
      end
    end
  end

  function automatic job_req_t mk(logic req, logic [BurstW-1:0] b);
    job_req_t j;
    j.req = req; j.burst = b;
    return j;
  endfunction

  function automatic logic [BurstW-1:0] rand_burst();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'hFFFF;
      2: return 16'h0;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic drain();
    while (pending_jobs.size() != 0 || expected_res.size() != 0) @(posedge clk_i);
    feeding = 0;
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_quantum(logic [3:0] q);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= q;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sch_quantum = q;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one phase: arrivals mixed with ticks
  task automatic random_phase(int n, bit fill_heavy);
    int act;
    for (int i = 0; i < n; i++) begin
      act = fill_heavy ? $urandom_range(0, 2) : $urandom_range(0, 4);
      if (act == 0) pending_jobs.insert(pending_jobs.size(), mk(ReqArrive, rand_burst()));
      else if (act == 1 && $urandom_range(0, 7) == 0)
        pending_jobs.insert(pending_jobs.size(),
                            mk(ReqArrive, 16'($urandom_range(0, 65535))));
      else pending_jobs.insert(pending_jobs.size(),
                               mk(ReqTick, 16'($urandom_range(0, 65535))));
    end
  endtask

  initial begin
    int q_list [6] = '{4, 1, 15, 0, 2, 7};
    sched_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: idle tick, zero burst, extremes, fill to rejection
    pending_jobs.insert(pending_jobs.size(), mk(ReqTick, 16'hFFFF));
    pending_jobs.insert(pending_jobs.size(), mk(ReqArrive, 16'h0));
    pending_jobs.insert(pending_jobs.size(), mk(ReqArrive, 16'hFFFF));
    pending_jobs.insert(pending_jobs.size(), mk(ReqArrive, 16'h0001));
    for (int i = 0; i < 15; i++)
      pending_jobs.insert(pending_jobs.size(), mk(ReqArrive, 16'd6));
    pending_jobs.insert(pending_jobs.size(), mk(ReqArrive, 16'h5555));
    for (int i = 0; i < 4; i++)
      pending_jobs.insert(pending_jobs.size(), mk(ReqTick, 16'hAAAA));
    feeding = 1;
    drain();
    set_quantum(4'd1);
    sched_reset_keep();
    feeding = 1;
    for (int i = 0; i < 4; i++) pending_jobs.insert(pending_jobs.size(), mk(ReqTick, '0));
    drain();

    // long receiver hold-off while items keep coming
    hold_off = 1;
    random_phase(40, 1);
    feeding = 1;
    repeat (400) @(posedge clk_i);
    hold_off = 0;
    drain();

    for (int p = 0; p < 6; p++) begin
      set_quantum(4'(q_list[p]));
      random_phase(250, p % 2);
      feeding = 1;
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // slots stay occupied across a register write; only the quantum changes
  function automatic void sched_reset_keep();
  endfunction

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
